>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect signals named clk and rst_n
// in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define HPT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform package
// Request and result types, operation codes, controller states and the
// status structs that travel between the datapath units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

  // Fixed widths of the channel fields and of the coefficient store.
  localparam int FIELD_W  = 32;
  localparam int COEF_W   = 32;
  localparam int NUM_COEF = 16;
  localparam int IDX_W    = 4;
  localparam int VEC_LEN  = 4;
  localparam int ROW_W    = 2;
  localparam int LANES    = 3;

  // Row of the matrix that produces the homogeneous w component.
  localparam logic [ROW_W-1:0] ROW_W_COMP = 2'd3;
  // First column of a row, where accumulation restarts.
  localparam logic [ROW_W-1:0] COL_FIRST  = 2'd0;
  // Last column of a row, where the row sum is complete.
  localparam logic [ROW_W-1:0] COL_LAST   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_XFORM_4D = 2'd1,
    OP_XFORM_3D = 2'd2,
    OP_XFORM_2D = 2'd3
  } hpt_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_FINISH
  } hpt_state_t;

  typedef struct packed {
    hpt_op_t                   operation;
    logic [IDX_W-1:0]          coef_index;
    logic signed [FIELD_W-1:0] coef_value;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic signed [FIELD_W-1:0] in_w;
  } hpt_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      w_is_zero;
    logic                      saturated;
  } hpt_rsp_t;

  // Completed row sum from the multiply-accumulate unit.
  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] idx;
    logic             sat;
  } hpt_row_t;

  // Divider status: completion pulse and per-lane clamp flags.
  typedef struct packed {
    logic             done;
    logic [LANES-1:0] sat;
  } hpt_div_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/hpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hpt_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Walks the sixteen coefficients row by row, multiplies each by its vector
// component on one shared multiplier and accumulates the row sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_mac import hpt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [VEC_LEN-1:0][COEF_W-1:0]  vec,
  input  wire logic [NUM_COEF-1:0]             coef_valid,
  output logic                                 rd_en,
  output logic      [IDX_W-1:0]                rd_addr,
  input  wire logic [COEF_W-1:0]               rd_data,
  output hpt_row_t                             row_sts,
  output logic      [DATA_WIDTH-1:0]           row_val
);

  localparam int PROD_W = 2 * COEF_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  // Four signed terms need two growth bits over the signed term width.
  localparam int ACC_W  = (TERM_W + 3 > DATA_WIDTH + 1) ? TERM_W + 3 : DATA_WIDTH + 1;

  localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [DATA_WIDTH-1:0] OUT_HI = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] OUT_LO = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  logic                     busy_r;
  logic [IDX_W-1:0]         k_r;
  logic                     s1_vld_r;
  logic [IDX_W-1:0]         s1_k_r;
  logic [ROW_W-1:0]         s1_row;
  logic [ROW_W-1:0]         s1_col;
  logic [COEF_W-1:0]        coef;
  logic [COEF_W-1:0]        opnd;
  logic [COEF_W-1:0]        mag_c;
  logic [COEF_W-1:0]        mag_o;
  logic [PROD_W-1:0]        mul;
  logic                     s2_vld_r;
  logic [IDX_W-1:0]         s2_k_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_r;
  logic [ROW_W-1:0]         s2_col;
  logic [ACC_W-1:0]         term_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     row_vld_r;
  logic [ROW_W-1:0]         row_idx_r;
  logic                     row_sat_r;
  logic [DATA_WIDTH-1:0]    row_val_r;

  // Read sequencer: k counts row-major, the store is addressed column-major.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (busy_r) begin
      k_r <= k_r + 1'b1;
      if (k_r == IDX_W'(NUM_COEF - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rd_en   = busy_r;
  assign rd_addr = {k_r[ROW_W-1:0], k_r[IDX_W-1:ROW_W]};

  // Stage one tracks the read that is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r <= k_r;
  end

  // Never-written slots read as the identity matrix.
  assign s1_col = s1_k_r[ROW_W-1:0];
  assign s1_row = s1_k_r[IDX_W-1:ROW_W];
  assign coef   = coef_valid[{s1_col, s1_row}] ? rd_data :
                  ((s1_row == s1_col) ? ONE : '0);
  assign opnd   = vec[s1_col];

  // Sign-magnitude multiply so the shift truncates toward zero.
  assign mag_c = coef[COEF_W-1] ? (~coef + 1'b1) : coef;
  assign mag_o = opnd[COEF_W-1] ? (~opnd + 1'b1) : opnd;
  assign mul   = mag_c * mag_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_k_r <= s1_k_r;
    prod_r <= mul;
    neg_r  <= coef[COEF_W-1] ^ opnd[COEF_W-1];
  end

  // Stage two: scale, restore the sign and accumulate across the row.
  assign s2_col   = s2_k_r[ROW_W-1:0];
  assign term_ext = {{(ACC_W - TERM_W){1'b0}}, prod_r[PROD_W-1:FRAC_BITS]};
  assign term     = neg_r ? (~term_ext + 1'b1) : term_ext;
  assign sum      = ((s2_col == COL_FIRST) ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_r <= sum;
    end
  end

  // Clamp the finished row sum to the data width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= 1'b0;
    end else begin
      row_vld_r <= s2_vld_r && (s2_col == COL_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && (s2_col == COL_LAST)) begin
      row_idx_r <= s2_k_r[IDX_W-1:ROW_W];
      if (sum > SAT_HI) begin
        row_val_r <= OUT_HI;
        row_sat_r <= 1'b1;
      end else if (sum < SAT_LO) begin
        row_val_r <= OUT_LO;
        row_sat_r <= 1'b1;
      end else begin
        row_val_r <= sum[DATA_WIDTH-1:0];
        row_sat_r <= 1'b0;
      end
    end
  end

  assign row_sts.vld = row_vld_r;
  assign row_sts.idx = row_idx_r;
  assign row_sts.sat = row_sat_r;
  assign row_val     = row_val_r;

endmodule

`default_nettype wire

>>> rtl/core/hpt_div.sv
// ----------------------------------------------------------------------------
// Perspective divider
// Three restoring divider lanes that share one divisor and retire one
// quotient bit each per cycle, then clamp to the data width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_div import hpt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [LANES-1:0][DATA_WIDTH-1:0]  num,
  input  wire logic [DATA_WIDTH-1:0]             den,
  output logic      [LANES-1:0][DATA_WIDTH-1:0]  quo,
  output hpt_div_sts_t                           sts
);

  localparam int QW    = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  localparam logic [DATA_WIDTH-1:0] OUT_HI = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] OUT_LO = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic [FRAC_BITS:0]    HIGH_ONE = {{FRAC_BITS{1'b0}}, 1'b1};

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] ud_r;
  logic [DATA_WIDTH-1:0] ud_nxt;

  assign ud_nxt = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;

  // Shared bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud_r <= ud_nxt;
    end
  end

  assign sts.done = done_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic                  neg_r;
    logic [DATA_WIDTH-1:0] rem_r;
    logic [QW-1:0]         dvd_r;
    logic [DATA_WIDTH-1:0] un;
    logic [DATA_WIDTH:0]   trial;
    logic [FRAC_BITS:0]    high;
    logic                  is_min;
    logic                  lane_sat;

    assign un    = num[i][DATA_WIDTH-1] ? (~num[i] + 1'b1) : num[i];
    assign trial = {rem_r, dvd_r[QW-1]} - {1'b0, ud_r};

    // The dividend register shifts out numerator bits and takes in quotient bits.
    always_ff @(posedge clk) begin
      if (start) begin
        neg_r <= num[i][DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
        rem_r <= '0;
        dvd_r <= {un, {FRAC_BITS{1'b0}}};
      end else if (busy_r) begin
        if (!trial[DATA_WIDTH]) begin
          rem_r <= trial[DATA_WIDTH-1:0];
          dvd_r <= {dvd_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DATA_WIDTH-2:0], dvd_r[QW-1]};
          dvd_r <= {dvd_r[QW-2:0], 1'b0};
        end
      end
    end

    // Clamp: the negative range reaches one step further than the positive one.
    assign high   = dvd_r[QW-1:DATA_WIDTH-1];
    assign is_min = (high == HIGH_ONE) && (dvd_r[DATA_WIDTH-2:0] == '0);

    always_comb begin
      if (neg_r) begin
        lane_sat = (high != '0) && !is_min;
        quo[i]   = lane_sat ? OUT_LO : (~dvd_r[DATA_WIDTH-1:0] + 1'b1);
      end else begin
        lane_sat = (high != '0);
        quo[i]   = lane_sat ? OUT_HI : dvd_r[DATA_WIDTH-1:0];
      end
    end

    assign sts.sat[i] = lane_sat;
  end

endmodule

`default_nettype wire

>>> rtl/core/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform
// 4x4 fixed-point matrix times vector with optional perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_stall / in_data; results leave on
//   out_valid / out_stall / out_data. A request is taken when valid is high
//   and stall is low at a rising clock edge.
//   A load request writes one coefficient and gives no result.
//   A 4D transform runs the multiply-accumulate phase and then loads its
//   result into the output register; the next request is taken once the
//   controller is back in idle. A 3D or 2D transform adds the perspective
//   divide between the two, which is skipped when the w row sum is zero. The
//   sixteen products share one multiplier fed from the coefficient RAM one
//   entry per cycle, and the divide retires one quotient bit per cycle in
//   three parallel lanes.
//   One transform is in flight at a time; in_stall is high while it runs.
//   After reset the matrix reads as identity; no clearing pass is needed.
//   A result waits in the output register while out_stall is high, and new
//   requests are still accepted; a following transform holds in its last
//   state until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire hpt_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output hpt_rsp_t      out_data
);

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1) << FRAC_BITS;

  hpt_state_t                             state_r;
  hpt_state_t                             state_nxt;
  hpt_op_t                                op_r;
  logic [VEC_LEN-1:0][COEF_W-1:0]         vec_r;
  logic [NUM_COEF-1:0]                    coef_valid_r;
  logic [VEC_LEN-1:0][DATA_WIDTH-1:0]     res_r;
  logic [VEC_LEN-1:0]                     flg_r;
  logic                                   out_valid_r;
  hpt_rsp_t                               out_data_r;
  hpt_rsp_t                               rsp_nxt;

  logic                                   accept;
  logic                                   load_wr;
  logic                                   mac_start;
  logic                                   div_start;
  logic                                   out_load;

  logic                                   rd_en;
  logic [IDX_W-1:0]                       rd_addr;
  logic [COEF_W-1:0]                      rd_data;
  hpt_row_t                               row_sts;
  logic [DATA_WIDTH-1:0]                  row_val;
  logic [LANES-1:0][DATA_WIDTH-1:0]       quo;
  hpt_div_sts_t                           div_sts;

  logic [VEC_LEN-1:0][DATA_WIDTH+FIELD_W-1:0] res_ext;
  logic [LANES-1:0][DATA_WIDTH+FIELD_W-1:0]   quo_ext;
  logic                                       w_zero;
  logic                                       div_sat;

  assign accept = in_valid && !in_stall;

  // Coefficient store.
  hpt_ram #(
    .WIDTH (COEF_W),
    .DEPTH (NUM_COEF)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (in_data.coef_index),
    .wr_data (in_data.coef_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slots that were loaded since reset; the rest read as identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_valid_r <= '0;
    end else if (load_wr) begin
      coef_valid_r[in_data.coef_index] <= 1'b1;
    end
  end

  hpt_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mac_start),
    .vec        (vec_r),
    .coef_valid (coef_valid_r),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .row_sts    (row_sts),
    .row_val    (row_val)
  );

  hpt_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (res_r[LANES-1:0]),
    .den   (res_r[ROW_W_COMP]),
    .quo   (quo),
    .sts   (div_sts)
  );

  // Capture the vector of a transform request with the mode substitutions.
  always_ff @(posedge clk) begin
    if (mac_start) begin
      op_r     <= in_data.operation;
      vec_r[0] <= in_data.in_x;
      vec_r[1] <= in_data.in_y;
      vec_r[2] <= (in_data.operation == OP_XFORM_2D) ? '0 : in_data.in_z;
      vec_r[3] <= (in_data.operation == OP_XFORM_4D) ? in_data.in_w : ONE;
    end
  end

  // Row results and their clamp flags.
  always_ff @(posedge clk) begin
    if (row_sts.vld) begin
      res_r[row_sts.idx] <= row_val;
      flg_r[row_sts.idx] <= row_sts.sat;
    end
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Controller next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.operation != OP_LOAD)) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (row_sts.vld && (row_sts.idx == ROW_W_COMP)) begin
          if ((op_r == OP_XFORM_4D) || (row_val == '0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_sts.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall  = 1'b1;
    load_wr   = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        load_wr   = in_valid && (in_data.operation == OP_LOAD);
        mac_start = in_valid && (in_data.operation != OP_LOAD);
      end
      ST_DIV_START: begin
        div_start = 1'b1;
      end
      ST_FINISH: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Sign-extend internal values to the field width.
  for (genvar i = 0; i < VEC_LEN; i++) begin : g_res_ext
    assign res_ext[i] = {{FIELD_W{res_r[i][DATA_WIDTH-1]}}, res_r[i]};
  end

  for (genvar i = 0; i < LANES; i++) begin : g_quo_ext
    assign quo_ext[i] = {{FIELD_W{quo[i][DATA_WIDTH-1]}}, quo[i]};
  end

  // Assemble the result for the current mode.
  assign w_zero  = (op_r != OP_XFORM_4D) && (res_r[ROW_W_COMP] == '0);
  assign div_sat = div_sts.sat[0] || div_sts.sat[1] ||
                   ((op_r == OP_XFORM_3D) && div_sts.sat[2]);

  always_comb begin
    rsp_nxt.out_w     = res_ext[3][FIELD_W-1:0];
    rsp_nxt.w_is_zero = w_zero;
    if (op_r == OP_XFORM_4D) begin
      rsp_nxt.out_x     = res_ext[0][FIELD_W-1:0];
      rsp_nxt.out_y     = res_ext[1][FIELD_W-1:0];
      rsp_nxt.out_z     = res_ext[2][FIELD_W-1:0];
      rsp_nxt.saturated = |flg_r;
    end else if (w_zero) begin
      rsp_nxt.out_x     = '0;
      rsp_nxt.out_y     = '0;
      rsp_nxt.out_z     = '0;
      rsp_nxt.saturated = 1'b0;
    end else begin
      rsp_nxt.out_x     = quo_ext[0][FIELD_W-1:0];
      rsp_nxt.out_y     = quo_ext[1][FIELD_W-1:0];
      rsp_nxt.out_z     = (op_r == OP_XFORM_3D) ? quo_ext[2][FIELD_W-1:0] : '0;
      rsp_nxt.saturated = flg_r[0] || flg_r[1] || flg_r[3] || div_sat ||
                          ((op_r == OP_XFORM_3D) && flg_r[2]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencing of the datapath units.
  `HPT_ASSERT_IMPLY(a_row_in_mac, row_sts.vld, state_r == ST_MAC, "row result outside MAC phase")
  `HPT_ASSERT_IMPLY(a_div_done_in_run, div_sts.done, state_r == ST_DIV_RUN, "divider done out of phase")
  `HPT_ASSERT_IMPLY(a_div_nonzero, div_start, res_r[ROW_W_COMP] != '0, "divide started with zero w")
  `HPT_ASSERT_IMPLY(a_flags_excl, out_valid_r, !(out_data_r.w_is_zero && out_data_r.saturated), "zero w result flagged saturated")
  `HPT_ASSERT_NEXT(a_load_shows, out_load, out_valid_r, "loaded result not presented")

endmodule

`default_nettype wire
